// File: sv/sst_pkg.sv
// shared constants, codes and request types for the sparse set table
`timescale 1ns / 1ps

package sst_pkg;

    // store depths
    localparam int KEY_DEPTH   = 1024;
    localparam int DENSE_DEPTH = 1024;

    // widths derived from the depths
    localparam int KAW   = $clog2(KEY_DEPTH);
    localparam int POS_W = $clog2(DENSE_DEPTH);
    localparam int CNT_W = POS_W + 1;

    // request field widths
    localparam int KEY_W     = 16;
    localparam int OP_W      = 2;
    localparam int STATUS_W  = 3;
    localparam int REG_W     = 11;
    localparam int CFG_IDX_W = 1;
    localparam int LIM_W     = KEY_W + 1;

    // limit register reset value
    localparam logic [REG_W-1:0] LIMIT_RESET = REG_W'(1024);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAP_LIMIT = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_QUERY  = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_FOUND     = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_INVALID   = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

    // one sparse map entry
    typedef struct packed {
        logic             valid;
        logic [POS_W-1:0] pos;
    } t_map_ent;

    // sparse map access
    typedef struct packed {
        logic           rd_en;
        logic [KAW-1:0] rd_addr;
        logic           wr_en;
        logic [KAW-1:0] wr_addr;
        t_map_ent       wr_data;
    } t_map_req;

    // dense list access
    typedef struct packed {
        logic             rd_en;
        logic [POS_W-1:0] rd_addr;
        logic             wr_en;
        logic [POS_W-1:0] wr_addr;
        logic [KAW-1:0]   wr_data;
    } t_dense_req;

endpackage

// File: sv/sst_map.sv
// sparse map memory with a clearing sweep after reset
`timescale 1ns / 1ps

module sst_map (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sst_pkg::t_map_req i_req,
    output sst_pkg::t_map_ent o_rdata,
    output logic              o_clr_busy
);
    import sst_pkg::*;

    t_map_ent       r_mem [KEY_DEPTH];
    t_map_ent       r_rdata;
    logic           r_clearing;
    logic [KAW-1:0] r_clr_addr;

    // clearing sweep, one entry a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + KAW'(1);
            if (r_clr_addr == KAW'(KEY_DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // write port
    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rdata <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rdata    = r_rdata;
    assign o_clr_busy = r_clearing;

endmodule

// File: sv/sst_dense.sv
// dense key list memory
`timescale 1ns / 1ps

module sst_dense (
    input  logic                    i_clk,
    input  sst_pkg::t_dense_req     i_req,
    output logic [sst_pkg::KAW-1:0] o_rdata
);
    import sst_pkg::*;

    logic [KAW-1:0] r_mem [DENSE_DEPTH];
    logic [KAW-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rdata <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/sst_ctrl.sv
// operation sequencer: limits, entry count, read-modify-write of both stores
`timescale 1ns / 1ps

module sst_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic                          i_cfg_we,
    input  logic [sst_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [sst_pkg::REG_W-1:0]     i_cfg_wdata,
    input  logic [sst_pkg::OP_W-1:0]      i_op,
    input  logic [sst_pkg::KEY_W-1:0]     i_key,
    input  logic [sst_pkg::POS_W-1:0]     i_dense_position,
    input  logic                          i_clr_busy,
    output sst_pkg::t_map_req             o_map_req,
    input  sst_pkg::t_map_ent             i_map_rdata,
    output sst_pkg::t_dense_req           o_dense_req,
    input  logic [sst_pkg::KAW-1:0]       i_dense_rdata,
    output logic                          o_valid,
    output logic [sst_pkg::STATUS_W-1:0]  o_status,
    output logic [sst_pkg::POS_W-1:0]     o_slot_index,
    output logic [sst_pkg::KAW-1:0]       o_key_out,
    output logic [sst_pkg::CNT_W-1:0]     o_entry_count_out
);
    import sst_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EVAL = 3'b010,
        S_FIX  = 3'b100
    } t_state;

    t_state           r_state, n_state;
    logic [REG_W-1:0] r_key_limit, r_cap_limit;
    logic [CNT_W-1:0] r_count, n_count;
    t_op              r_op, n_op;
    logic [KAW-1:0]   r_key, n_key;
    logic             r_bad, n_bad;
    logic [KAW-1:0]   r_moved, n_moved;
    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_valid, n_valid;
    t_status          r_status, n_status;
    logic [POS_W-1:0] r_slot, n_slot;
    logic [KAW-1:0]   r_kout, n_kout;
    logic [CNT_W-1:0] r_cnt_out, n_cnt_out;

    logic             w_accept;
    logic [LIM_W-1:0] w_eff_key, w_eff_cap;
    logic [CNT_W-1:0] w_last;
    logic             w_full;

    // effective limits and derived values
    assign w_eff_key = (LIM_W'(r_key_limit) < LIM_W'(KEY_DEPTH)) ?
                       LIM_W'(r_key_limit) : LIM_W'(KEY_DEPTH);
    assign w_eff_cap = (LIM_W'(r_cap_limit) < LIM_W'(DENSE_DEPTH)) ?
                       LIM_W'(r_cap_limit) : LIM_W'(DENSE_DEPTH);
    assign w_last    = r_count - CNT_W'(1);
    assign w_full    = LIM_W'(r_count) >= w_eff_cap;
    assign w_accept  = i_start && (r_state == S_IDLE) && !i_clr_busy;
    assign o_busy    = (r_state != S_IDLE) || i_clr_busy;

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_op      = r_op;
        n_key     = r_key;
        n_bad     = r_bad;
        n_moved   = r_moved;
        n_pos     = r_pos;
        n_valid   = 1'b0;
        n_status  = r_status;
        n_slot    = r_slot;
        n_kout    = r_kout;
        n_cnt_out = r_cnt_out;
        o_map_req   = '0;
        o_dense_req = '0;
        case (r_state)
            S_IDLE: begin
                // issue both reads on the accepting edge
                o_map_req.rd_en     = w_accept;
                o_map_req.rd_addr   = i_key[KAW-1:0];
                o_dense_req.rd_en   = w_accept;
                o_dense_req.rd_addr = (t_op'(i_op) == OP_READ) ?
                                      i_dense_position : w_last[POS_W-1:0];
                if (w_accept) begin
                    n_op    = t_op'(i_op);
                    n_key   = i_key[KAW-1:0];
                    n_bad   = (t_op'(i_op) == OP_READ) ?
                              (CNT_W'(i_dense_position) >= r_count) :
                              (LIM_W'(i_key) >= w_eff_key);
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_valid  = 1'b1;
                n_state  = S_IDLE;
                n_status = ST_OK;
                n_slot   = '0;
                n_kout   = '0;
                if (r_bad) begin
                    n_status = ST_INVALID;
                end else begin
                    case (r_op)
                        OP_QUERY: begin
                            if (i_map_rdata.valid) begin
                                n_status = ST_FOUND;
                                n_slot   = i_map_rdata.pos;
                            end else begin
                                n_status = ST_NOT_FOUND;
                            end
                        end
                        OP_INSERT: begin
                            if (i_map_rdata.valid) begin
                                n_status = ST_FOUND;
                                n_slot   = i_map_rdata.pos;
                            end else if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                // append at the end of the dense list
                                n_slot                     = r_count[POS_W-1:0];
                                n_count                    = r_count + CNT_W'(1);
                                o_map_req.wr_en            = 1'b1;
                                o_map_req.wr_addr          = r_key;
                                o_map_req.wr_data.valid    = 1'b1;
                                o_map_req.wr_data.pos      = r_count[POS_W-1:0];
                                o_dense_req.wr_en          = 1'b1;
                                o_dense_req.wr_addr        = r_count[POS_W-1:0];
                                o_dense_req.wr_data        = r_key;
                            end
                        end
                        OP_REMOVE: begin
                            if (!i_map_rdata.valid) begin
                                n_status = ST_NOT_FOUND;
                            end else begin
                                // drop the key, move the last entry into its hole
                                n_count           = w_last;
                                o_map_req.wr_en   = 1'b1;
                                o_map_req.wr_addr = r_key;
                                o_map_req.wr_data = '0;
                                if (CNT_W'(i_map_rdata.pos) != w_last) begin
                                    o_dense_req.wr_en   = 1'b1;
                                    o_dense_req.wr_addr = i_map_rdata.pos;
                                    o_dense_req.wr_data = i_dense_rdata;
                                    n_moved             = i_dense_rdata;
                                    n_pos               = i_map_rdata.pos;
                                    n_state             = S_FIX;
                                end
                            end
                        end
                        OP_READ: begin
                            n_kout = i_dense_rdata;
                        end
                        default: begin
                            n_status = ST_INVALID;
                        end
                    endcase
                end
                n_cnt_out = n_count;
            end
            S_FIX: begin
                // repoint the moved key at its new position
                o_map_req.wr_en         = 1'b1;
                o_map_req.wr_addr       = r_moved;
                o_map_req.wr_data.valid = 1'b1;
                o_map_req.wr_data.pos   = r_pos;
                n_state                 = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_valid     <= 1'b0;
            r_key_limit <= LIMIT_RESET;
            r_cap_limit <= LIMIT_RESET;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_KEY_LIMIT: r_key_limit <= i_cfg_wdata;
                    CFG_CAP_LIMIT: r_cap_limit <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_key     <= n_key;
        r_bad     <= n_bad;
        r_moved   <= n_moved;
        r_pos     <= n_pos;
        r_status  <= n_status;
        r_slot    <= n_slot;
        r_kout    <= n_kout;
        r_cnt_out <= n_cnt_out;
    end

    assign o_valid           = r_valid;
    assign o_status          = r_status;
    assign o_slot_index      = r_slot;
    assign o_key_out         = r_kout;
    assign o_entry_count_out = r_cnt_out;

    // a result follows an evaluation cycle only
    a_result_after_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> $past(r_state == S_EVAL))
        else $error("result strobe without an evaluation cycle");

    // an accepted request is evaluated in the next cycle
    a_accept_to_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_EVAL))
        else $error("accepted request not evaluated");

    // no request is taken during the clearing sweep
    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_clr_busy |-> !w_accept && !o_map_req.wr_en)
        else $error("map access during clearing sweep");

    // the entry count stays within the dense list
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DENSE_DEPTH))
        else $error("entry count beyond dense depth");

    // the fix-up cycle always returns to idle
    a_fix_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIX) |=> (r_state == S_IDLE))
        else $error("fix-up cycle did not return to idle");

endmodule

// File: sv/sparse_set_table.sv
// sparse set table top level: sequencer, sparse map and dense list
// the accepting edge captures the request and reads both stores; result and strobe are registered
// together at the end of evaluate; a new request is taken only in idle, after evaluate and write back
//   plus, for a remove that moves an entry, a fix-up where the single map write port repoints its key
// reset: synchronous, active low; a sweep then clears all 1024 entries of the sparse map,
//   busy stays high meanwhile and register writes are still taken
// the receiver cannot stall: each result is shown for exactly one cycle
`timescale 1ns / 1ps

module sparse_set_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_cfg_we,
    input  logic [sst_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [sst_pkg::REG_W-1:0]     i_cfg_wdata,
    input  logic [sst_pkg::OP_W-1:0]      i_op,
    input  logic [sst_pkg::KEY_W-1:0]     i_key,
    input  logic [sst_pkg::POS_W-1:0]     i_dense_position,
    output logic                          o_valid,
    output logic [sst_pkg::STATUS_W-1:0]  o_status,
    output logic [sst_pkg::POS_W-1:0]     o_slot_index,
    output logic [sst_pkg::KAW-1:0]       o_key_out,
    output logic [sst_pkg::CNT_W-1:0]     o_entry_count_out
);
    import sst_pkg::*;

    t_map_req       w_map_req;
    t_map_ent       w_map_rdata;
    t_dense_req     w_dense_req;
    logic [KAW-1:0] w_dense_rdata;
    logic           w_clr_busy;

    // sequencer
    sst_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .o_busy           (busy),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_op             (i_op),
        .i_key            (i_key),
        .i_dense_position (i_dense_position),
        .i_clr_busy       (w_clr_busy),
        .o_map_req        (w_map_req),
        .i_map_rdata      (w_map_rdata),
        .o_dense_req      (w_dense_req),
        .i_dense_rdata    (w_dense_rdata),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_slot_index     (o_slot_index),
        .o_key_out        (o_key_out),
        .o_entry_count_out(o_entry_count_out)
    );

    // sparse map
    sst_map u_map (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_map_req),
        .o_rdata    (w_map_rdata),
        .o_clr_busy (w_clr_busy)
    );

    // dense list
    sst_dense u_dense (
        .i_clk   (i_clk),
        .i_req   (w_dense_req),
        .o_rdata (w_dense_rdata)
    );

endmodule
